FILE: rtl/core/ddo_pkg.sv
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS    = 64;
  localparam int ITER_W       = 6;
  localparam int CFG_IDX_W    = 8;

  localparam logic [31:0] MPT_RESET   = 32'd1756856;
  localparam logic [31:0] ITW_RESET   = 32'd93206756;
  localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;
  localparam logic [31:0] RAD_TO_BIN  = 32'd2734261102;
  localparam logic [31:0] US_PER_S    = 32'd1000000;

  localparam logic [CFG_IDX_W-1:0] REG_MPT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ITW = CFG_IDX_W'(1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL0  = 12'b0000_0000_0010,
    S_MUL1  = 12'b0000_0000_0100,
    S_MUL2  = 12'b0000_0000_1000,
    S_MUL3  = 12'b0000_0001_0000,
    S_SUM   = 12'b0000_0010_0000,
    S_CPREP = 12'b0000_0100_0000,
    S_CITER = 12'b0000_1000_0000,
    S_CFIN  = 12'b0001_0000_0000,
    S_DIV   = 12'b0010_0000_0000,
    S_DFIN  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [3:0] {
    ST_DL, ST_DR, ST_RAD, ST_DTH, ST_G1Y, ST_C1,
    ST_G2X, ST_G2Y, ST_C2, ST_VX, ST_VY, ST_VTH
  } step_t;

  typedef struct packed {
    state_t             phase;
    step_t              step;
    logic [ITER_W-1:0]  iter;
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic dt_zero;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] atan_bin(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/diff_drive_odometry.sv
`timescale 1ns / 1ps
// Processing: the first sample goes straight to output. Any other sample takes
// seven multiplies and two 24-step CORDIC rotations; unless its elapsed time is
// zero, three more multiplies and three restoring divisions follow. Each multiply
// runs through states MUL0 to MUL3 and is built from 32x32 partial products.
// Input: one sample is taken at a time; the next is taken while a result waits.
// Reset (rst_n low, synchronous): pose, previous counts and first-sample flag
// clear, registers return to their defaults, output goes empty.
module diff_drive_odometry (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [95:0]                       in_tdata,   // left_count, right_count, elapsed_us
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [223:0]                      out_tdata,  // pos_x, pos_y, heading, speed_local_x,
                                                        // speed_local_y, turn_rate
  output logic [1:0]                        out_tuser,  // first_sample, zero_time
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import ddo_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ddo_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

FILE: rtl/core/ddo_ctrl.sv
`timescale 1ns / 1ps
module ddo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ddo_pkg::sts_t sts,
  output ddo_pkg::cmd_t cmd
);
  import ddo_pkg::*;

  state_t            state_r, state_nxt;
  step_t             step_r, step_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign cmd.phase = state_r;
  assign cmd.step  = step_r;
  assign cmd.iter  = cnt_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          step_nxt  = ST_DL;
          state_nxt = sts.have_prev ? S_MUL0 : S_OUT;
        end
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: begin
        state_nxt = S_MUL0;
        unique case (step_r) inside
          ST_DL:  step_nxt = ST_DR;
          ST_DR:  state_nxt = S_SUM;
          ST_RAD: step_nxt = ST_DTH;
          ST_DTH: step_nxt = ST_G1Y;
          ST_G1Y: begin
            step_nxt  = ST_C1;
            state_nxt = S_CPREP;
          end
          ST_G2X: step_nxt = ST_G2Y;
          ST_G2Y: begin
            step_nxt  = ST_C2;
            state_nxt = S_CPREP;
          end
          ST_VX, ST_VY, ST_VTH: begin
            state_nxt = S_DIV;
            cnt_nxt   = '0;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SUM: begin
        step_nxt  = ST_RAD;
        state_nxt = S_MUL0;
      end
      S_CPREP: begin
        cnt_nxt   = '0;
        state_nxt = S_CITER;
      end
      S_CITER: begin
        if (cnt_r == ITER_W'(CORDIC_STEPS - 1)) state_nxt = S_CFIN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_CFIN: begin
        if (step_r == ST_C1) begin
          step_nxt  = ST_G2X;
          state_nxt = S_MUL0;
        end else if (sts.dt_zero) begin
          state_nxt = S_OUT;
        end else begin
          step_nxt  = ST_VX;
          state_nxt = S_MUL0;
        end
      end
      S_DIV: begin
        if (cnt_r == ITER_W'(DIV_STEPS - 1)) state_nxt = S_DFIN;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_DFIN: begin
        state_nxt = S_MUL0;
        unique case (step_r)
          ST_VX:   step_nxt = ST_VY;
          ST_VY:   step_nxt = ST_VTH;
          default: state_nxt = S_OUT;
        endcase
      end
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_DL;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_first_goes_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid && !sts.have_prev) |=> state_r == S_OUT)
    else $error("first sample did not go straight to output");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CITER |-> cnt_r < ITER_W'(CORDIC_STEPS))
    else $error("cordic iteration count overrun");

  a_div_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL3 && (step_r == ST_VX || step_r == ST_VY || step_r == ST_VTH))
      |=> (state_r == S_DIV && cnt_r == '0))
    else $error("divider not started from zero");

endmodule

FILE: rtl/core/ddo_dp.sv
`timescale 1ns / 1ps
module ddo_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ddo_pkg::cmd_t                      cmd,
  output ddo_pkg::sts_t                      sts,
  input  logic                               in_tvalid,
  input  logic [95:0]                        in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [223:0]                       out_tdata,
  output logic [1:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);
  import ddo_pkg::*;

  logic [31:0] mpt_r, itw_r;
  logic [31:0] prev_l_r, prev_rt_r;
  logic        have_prev_r;
  logic [47:0] acc_x_r, acc_y_r;
  logic [31:0] acc_hd_r;
  logic [31:0] dt_r;
  logic [31:0] dlt_l_r, dlt_rt_r;
  logic signed [63:0] dl_r, dr_r, d_r, diff_r, rad_r, lx_r, ly_r, cx_r, cy_r;
  logic [31:0] dth_r;
  logic signed [33:0] cz_r;
  logic        mneg_r;
  logic [31:0] mhi_r, mb_r;
  logic [63:0] pp_lo_r, pp_hi_r;
  logic [95:0] full_r;
  logic        dneg_r;
  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] vx_r, vy_r, vth_r;
  logic        first_r, zt_r;
  logic        out_valid_r;
  logic [223:0] out_data_r;
  logic [1:0]   out_user_r;

  logic               accept;
  logic signed [63:0] op_a;
  logic [31:0]        op_b;
  logic [6:0]         op_sh;
  logic [63:0]        op_mag;
  logic [95:0]        shifted;
  logic [63:0]        mag;
  logic signed [63:0] mres;
  logic signed [64:0] sum65;
  logic signed [64:0] half65;
  logic [31:0]        ang, ang_t, ang_f;
  logic signed [63:0] xs, ys;
  logic [31:0]        at;
  logic signed [63:0] cx_s8, cy_s8;
  logic [32:0]        dv_t, dv_d;
  logic               dv_ge;
  logic [31:0]        rate_q;
  logic [63:0]        quo_neg;

  assign accept     = (cmd.phase == S_IDLE) && in_tvalid;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign sts.have_prev = have_prev_r;
  assign sts.dt_zero   = (dt_r == '0);
  assign sts.out_free  = !out_valid_r || out_tready;

  // multiplier operand routing
  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_sh = 7'd8;
    unique case (cmd.step)
      ST_DL:  begin op_a = 64'(signed'(dlt_l_r));  op_b = mpt_r; end
      ST_DR:  begin op_a = 64'(signed'(dlt_rt_r)); op_b = mpt_r; end
      ST_RAD: begin op_a = diff_r; op_b = itw_r;       op_sh = 7'd24; end
      ST_DTH: begin op_a = rad_r;  op_b = RAD_TO_BIN;  op_sh = 7'd26; end
      ST_G1Y: begin op_a = d_r;    op_b = CORDIC_GAIN; op_sh = 7'd32; end
      ST_G2X: begin op_a = lx_r;   op_b = CORDIC_GAIN; op_sh = 7'd32; end
      ST_G2Y: begin op_a = ly_r;   op_b = CORDIC_GAIN; op_sh = 7'd32; end
      ST_VX:  begin op_a = lx_r;   op_b = US_PER_S; end
      ST_VY:  begin op_a = ly_r;   op_b = US_PER_S; end
      ST_VTH: begin op_a = rad_r;  op_b = US_PER_S; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_comb begin
    op_mag  = op_a[63] ? 64'(-op_a) : 64'(op_a);
    shifted = full_r >> op_sh;
    mag     = (|shifted[95:63]) ? {1'b0, {63{1'b1}}} : {1'b0, shifted[62:0]};
    mres    = mneg_r ? -$signed(mag) : $signed(mag);
    sum65   = 65'(dl_r) + 65'(dr_r);
    // halve, truncating toward zero
    half65  = (sum65 + 65'(sum65[64])) >>> 1;
    ang     = (cmd.step == ST_C1) ? dth_r : acc_hd_r;
    ang_t   = ang + 32'h4000_0000;
    ang_f   = ang_t[31] ? (ang ^ 32'h8000_0000) : ang;
    xs      = cx_r >>> cmd.iter[4:0];
    ys      = cy_r >>> cmd.iter[4:0];
    at      = atan_bin(cmd.iter[4:0]);
    cx_s8   = cx_r >>> 8;
    cy_s8   = cy_r >>> 8;
    dv_t    = {rem_r, quo_r[63]};
    dv_d    = {1'b0, dt_r};
    dv_ge   = (dv_t >= dv_d);
    quo_neg = -quo_r;
    if (!dneg_r) rate_q = (quo_r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_r[31:0];
    else rate_q = (quo_r > 64'h8000_0000) ? 32'h8000_0000 : quo_neg[31:0];
  end

  // configuration and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r       <= MPT_RESET;
      itw_r       <= ITW_RESET;
      prev_l_r    <= '0;
      prev_rt_r   <= '0;
      have_prev_r <= 1'b0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_hd_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_MPT) mpt_r <= cfg_data;
        else if (cfg_index == REG_ITW) itw_r <= cfg_data;
      end
      if (accept) begin
        prev_l_r    <= in_tdata[31:0];
        prev_rt_r   <= in_tdata[63:32];
        have_prev_r <= 1'b1;
      end
      if (cmd.phase == S_MUL3 && cmd.step == ST_DTH) acc_hd_r <= acc_hd_r + mres[31:0];
      if (cmd.phase == S_CFIN && cmd.step == ST_C2) begin
        acc_x_r <= acc_x_r + cx_s8[47:0];
        acc_y_r <= acc_y_r + cy_s8[47:0];
      end
      if (cmd.phase == S_OUT && sts.out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.phase)
      S_IDLE: begin
        if (accept) begin
          dlt_l_r  <= in_tdata[31:0] - prev_l_r;
          dlt_rt_r <= in_tdata[63:32] - prev_rt_r;
          dt_r     <= in_tdata[95:64];
          first_r  <= !have_prev_r;
          zt_r     <= have_prev_r && (in_tdata[95:64] == '0);
          vx_r     <= '0;
          vy_r     <= '0;
          vth_r    <= '0;
        end
      end
      S_MUL0: begin
        mneg_r  <= op_a[63];
        pp_lo_r <= op_mag[31:0] * op_b;
        mhi_r   <= op_mag[63:32];
        mb_r    <= op_b;
      end
      S_MUL1: pp_hi_r <= mhi_r * mb_r;
      S_MUL2: full_r <= {pp_hi_r, 32'b0} + {32'b0, pp_lo_r};
      S_MUL3: begin
        unique case (cmd.step)
          ST_DL:  dl_r <= mres;
          ST_DR:  dr_r <= mres;
          ST_RAD: rad_r <= mres;
          ST_DTH: dth_r <= mres[31:0];
          ST_G1Y: begin
            cx_r <= '0;
            cy_r <= mres;
          end
          ST_G2X: cx_r <= mres;
          ST_G2Y: cy_r <= mres;
          default: begin
            dneg_r <= mneg_r;
            quo_r  <= mag;
            rem_r  <= '0;
          end
        endcase
      end
      S_SUM: begin
        d_r    <= half65[63:0];
        diff_r <= dr_r - dl_r;
      end
      S_CPREP: begin
        if (ang_t[31]) begin
          cx_r <= -cx_r;
          cy_r <= -cy_r;
        end
        cz_r <= 34'(signed'(ang_f));
      end
      S_CITER: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - $signed({2'b0, at});
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + $signed({2'b0, at});
        end
      end
      S_CFIN: begin
        if (cmd.step == ST_C1) begin
          lx_r <= cx_r;
          ly_r <= cy_r;
        end
      end
      S_DIV: begin
        rem_r <= dv_ge ? 32'(dv_t - dv_d) : dv_t[31:0];
        quo_r <= {quo_r[62:0], dv_ge};
      end
      S_DFIN: begin
        unique case (cmd.step)
          ST_VX:   vx_r <= rate_q;
          ST_VY:   vy_r <= rate_q;
          default: vth_r <= rate_q;
        endcase
      end
      S_OUT: begin
        if (sts.out_free) begin
          out_data_r <= {vth_r, vy_r, vx_r, acc_hd_r, acc_y_r, acc_x_r};
          out_user_r <= {zt_r, first_r};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/tb_diff_drive_odometry.sv
`timescale 1ns / 1ps
module tb_diff_drive_odometry;
  import ddo_pkg::*;

  typedef struct {
    logic [47:0] px;
    logic [47:0] py;
    logic [31:0] hd;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vth;
    logic        first;
    logic        zt;
  } pose_rec_t;

  class odo_scoreboard;
    logic [31:0] mpt;
    logic [31:0] itw;
    logic [31:0] last_l;
    logic [31:0] last_r;
    logic        primed;
    logic [47:0] ax;
    logic [47:0] ay;
    logic [31:0] ahd;
    pose_rec_t   pending[$];
    int          errors;
    logic [31:0] atan_steps[32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1, 1, 0};

    function new();
      mpt = MPT_RESET;
      itw = ITW_RESET;
      last_l = '0;
      last_r = '0;
      primed = 1'b0;
      ax = '0;
      ay = '0;
      ahd = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == REG_MPT) mpt = val;
      else if (idx == REG_ITW) itw = val;
    endfunction

    // sign-magnitude product, truncated toward zero, saturated to +-(2^63-1)
    function longint mul_q(longint a, logic [31:0] b, int s);
      logic         neg;
      logic [63:0]  m;
      logic [127:0] p;
      logic [63:0]  r;
      neg = a < 0;
      m = neg ? 64'(-a) : 64'(a);
      p = {64'b0, m} * {96'b0, b};
      p = p >> s;
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF_FFFF;
      else r = p[63:0];
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function void rotate(inout longint x, inout longint y, input logic [31:0] ang);
      longint z;
      longint xs;
      longint ys;
      x = mul_q(x, CORDIC_GAIN, 32);
      y = mul_q(y, CORDIC_GAIN, 32);
      if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
        x = -x;
        y = -y;
        ang = ang - 32'h8000_0000;
      end
      z = longint'($signed(ang));
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'({32'b0, atan_steps[i]});
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'({32'b0, atan_steps[i]});
        end
      end
    endfunction

    function longint per_second(longint v, logic [31:0] dt);
      longint q;
      if (dt == 0) return 0;
      q = mul_q(v, US_PER_S, 8) / longint'({32'b0, dt});
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void note_sample(logic [31:0] l, logic [31:0] r, logic [31:0] dt);
      pose_rec_t e;
      longint    dl, dr, d, rad, lx, ly, wx, wy;
      logic [31:0] dth;
      logic [31:0] dlt;
      logic [31:0] drt;
      e.vx = '0;
      e.vy = '0;
      e.vth = '0;
      e.first = 1'b0;
      e.zt = 1'b0;
      if (!primed) begin
        primed = 1'b1;
        e.first = 1'b1;
      end else begin
        dlt = l - last_l;
        drt = r - last_r;
        dl = mul_q(longint'($signed(dlt)), mpt, 8);
        dr = mul_q(longint'($signed(drt)), mpt, 8);
        d = (dl + dr) / 2;
        rad = mul_q(dr - dl, itw, 24);
        dth = 32'(mul_q(rad, RAD_TO_BIN, 26));
        ahd = ahd + dth;
        lx = 0;
        ly = d;
        rotate(lx, ly, dth);
        wx = lx;
        wy = ly;
        rotate(wx, wy, ahd);
        ax = ax + 48'(wx >>> 8);
        ay = ay + 48'(wy >>> 8);
        if (dt == 0) begin
          e.zt = 1'b1;
        end else begin
          e.vx = 32'(per_second(lx, dt));
          e.vy = 32'(per_second(ly, dt));
          e.vth = 32'(per_second(rad, dt));
        end
      end
      last_l = l;
      last_r = r;
      e.px = ax;
      e.py = ay;
      e.hd = ahd;
      pending.push_back(e);
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, field, got, want);
      errors++;
    endtask

    task check_pose(logic [223:0] td, logic [1:0] tu);
      pose_rec_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected transfer", td[63:0], 64'd0);
        return;
      end
      e = pending.pop_front();
      if (td[47:0] !== e.px) report_mismatch("pos_x", td[47:0], e.px);
      if (td[95:48] !== e.py) report_mismatch("pos_y", td[95:48], e.py);
      if (td[127:96] !== e.hd) report_mismatch("heading", td[127:96], e.hd);
      if (td[159:128] !== e.vx) report_mismatch("speed_local_x", td[159:128], e.vx);
      if (td[191:160] !== e.vy) report_mismatch("speed_local_y", td[191:160], e.vy);
      if (td[223:192] !== e.vth) report_mismatch("turn_rate", td[223:192], e.vth);
      if (tu[0] !== e.first) report_mismatch("first_sample", tu[0], e.first);
      if (tu[1] !== e.zt) report_mismatch("zero_time", tu[1], e.zt);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [95:0]          in_tdata = '0;   // left_count, right_count, elapsed_us
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [223:0]         out_tdata;       // pos_x, pos_y, heading, speed_local_x,
                                         // speed_local_y, turn_rate
  logic [1:0]           out_tuser;       // first_sample, zero_time
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  odo_scoreboard sb = new();
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic [31:0]   cur_l = '0;
  logic [31:0]   cur_r = '0;

  diff_drive_odometry DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pose(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task send_sample(logic [31:0] l, logic [31:0] r, logic [31:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {dt, r, l};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(l, r, dt);
    cur_l = l;
    cur_r = r;
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // hold until every expected transfer is back and the core has settled
  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task random_sample();
    int          pick;
    logic [31:0] dt;
    pick = $urandom_range(99);
    dt = $urandom_range(150000, 50000);
    if (pick < 78) begin
      send_sample(cur_l + 32'($urandom_range(4000)) - 32'd2000,
                  cur_r + 32'($urandom_range(4000)) - 32'd2000, dt);
    end else if (pick < 86) begin
      send_sample(cur_l + 32'($urandom_range(300)), cur_r - 32'($urandom_range(300)), '0);
    end else if (pick < 93) begin
      send_sample($urandom, $urandom, $urandom);
    end else begin
      send_sample(cur_l + $urandom_range(1 << 20), cur_r - $urandom_range(1 << 20),
                  $urandom_range(10, 1));
    end
  endtask

  task random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) random_sample();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first sample, wraps, zero time, straight and turning
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd100000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd100000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_sample(32'h8000_0100, 32'h8000_0100, 32'd100000);
    send_sample(32'h8000_0000, 32'h8000_0200, 32'd1);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'd0);
    send_sample(32'h0000_1000, 32'h0000_0800, 32'd50000);
    send_sample(32'h0000_1000, 32'h0000_0800, 32'd50000);
    send_sample(32'h7FFF_0000, 32'h8000_FFFF, 32'd1);
    drain();
    write_reg(REG_MPT, 32'hFFFF_FFFF);
    write_reg(REG_ITW, 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(2), 32'h1234_5678);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'h0000_0000, 32'h0000_0000, 32'd3);
    drain();
    write_reg(REG_MPT, 32'd0);
    write_reg(REG_ITW, 32'd0);
    send_sample(32'h1234_5678, 32'h8765_4321, 32'd1000);
    send_sample(32'h0000_0000, 32'hFFFF_0000, 32'd0);
    drain();

    write_reg(REG_MPT, MPT_RESET);
    write_reg(REG_ITW, ITW_RESET);
    random_phase(430, 0, 0);
    drain();
    write_reg(REG_MPT, 32'hFFFF_FFFF);
    write_reg(REG_ITW, 32'd0);
    random_phase(300, 78, 0);
    drain();
    write_reg(REG_MPT, 32'd0);
    write_reg(REG_ITW, 32'hFFFF_FFFF);
    random_phase(300, 0, 78);
    drain();
    write_reg(REG_MPT, $urandom);
    write_reg(REG_ITW, $urandom);
    random_phase(300, 38, 38);
    drain();
    write_reg(REG_MPT, $urandom_range(1 << 24));
    write_reg(REG_ITW, $urandom_range(1 << 28));
    random_phase(100, 0, 0);
    random_phase(100, 78, 78);
    random_phase(100, 38, 0);
    drain();

    if (sb.errors == 0) begin
      $display("PASS diff_drive_odometry");
    end else begin
      $display("FAIL diff_drive_odometry");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("FAIL diff_drive_odometry");
    $finish;
  end

endmodule
